### src/asgs_pkg.sv
// Shared types, constants and helpers of the ADC group scan sequencer.
package asgs_pkg;

	localparam int GROUP_COUNT        = 4;
	localparam int CHANNELS_PER_GROUP = 8;
	localparam int UNIT_COUNT         = 2;

	// Fixed field layout of the configuration registers
	localparam int LIST_GROUPS = 4;
	localparam int SLOT_W      = 3;
	localparam int CHAN_W      = 5;
	localparam int COUNT_W     = 4;
	localparam int LIST_W      = 40;
	localparam int COUNTS_W    = 16;
	localparam int UMAP_W      = 4;
	localparam int SAMPLE_W    = 12;
	localparam int REG_IDX_W   = 3;

	localparam int GI_W   = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
	localparam int POS_W  = (CHANNELS_PER_GROUP > 1) ? $clog2(CHANNELS_PER_GROUP) : 1;
	localparam int STORE_DEPTH = GROUP_COUNT * CHANNELS_PER_GROUP;
	localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

	// Output queue of the back end
	localparam int OQ_DEPTH = 4;
	localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
	localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

	// Register indexes
	localparam logic [REG_IDX_W-1:0] REG_LIST_G0  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_COUNTS   = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_UNIT_MAP = 3'd5;

	typedef enum logic [2:0] {
		OP_INIT      = 3'd0,
		OP_BUF_READY = 3'd1,
		OP_START     = 3'd2,
		OP_POLL      = 3'd3,
		OP_READ      = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ERR_NONE       = 3'd0,
		ERR_UNINIT     = 3'd1,
		ERR_BAD_GROUP  = 3'd2,
		ERR_ALREADY    = 3'd3,
		ERR_BUF_UNSET  = 3'd4,
		ERR_BUSY       = 3'd5,
		ERR_NOT_DONE   = 3'd6
	} error_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_BUSY = 2'd1,
		ST_DONE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CMD_NONE    = 2'd0,
		CMD_START   = 2'd1,
		CMD_DISABLE = 2'd2
	} cmd_t;

	typedef enum logic {
		BK_IDLE,
		BK_READ
	} bk_state_t;

	typedef struct packed {
		logic                ok;
		error_t              error;
		status_t             status;
		cmd_t                cmd;
		logic                unit;
		logic [CHAN_W-1:0]   channel;
		logic [SAMPLE_W-1:0] value;
		logic                last;
	} result_t;

	// One classified op handed from front to back
	typedef struct packed {
		logic                is_read;
		logic                we;
		logic [ADDR_W-1:0]   waddr;
		logic [SAMPLE_W-1:0] wdata;
		logic [GI_W-1:0]     rgroup;
		logic [POS_W-1:0]    rlast;
		result_t             res;
	} job_t;

	function automatic logic [ADDR_W-1:0] store_addr(logic [GI_W-1:0] gi,
			logic [POS_W-1:0] pos);
		return ADDR_W'(int'(gi) * CHANNELS_PER_GROUP + int'(pos));
	endfunction

endpackage

### src/asgs_ram.sv
// Generic simple dual-port RAM with registered read.
module asgs_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### src/asgs_front.sv
// Front end: configuration, per-group state, op checking and job building.
module asgs_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [asgs_pkg::REG_IDX_W-1:0]    wr_index,
	input  logic [asgs_pkg::LIST_W-1:0]       wr_data,
	input  logic                              accept,
	input  logic [2:0]                        op,
	input  logic [3:0]                        group,
	input  logic                              conversion_done,
	input  logic [15:0]                       sample,
	output logic                              job_push,
	output asgs_pkg::job_t                    job
);

	localparam int GC  = asgs_pkg::GROUP_COUNT;
	localparam int CPG = asgs_pkg::CHANNELS_PER_GROUP;

	logic [asgs_pkg::LIST_W-1:0]   list_q [asgs_pkg::LIST_GROUPS];
	logic [asgs_pkg::COUNTS_W-1:0] counts_q;
	logic [asgs_pkg::UMAP_W-1:0]   umap_q;

	logic                        ready_q;
	logic [GC-1:0]               buf_q;
	asgs_pkg::status_t           status_q [GC];
	logic [asgs_pkg::POS_W-1:0]  pos_q [GC];

	logic                        gok;
	logic [asgs_pkg::GI_W-1:0]   gi;
	logic [1:0]                  ci;
	asgs_pkg::status_t           gstat;
	logic [asgs_pkg::COUNT_W-1:0] raw_cnt;
	logic [asgs_pkg::COUNT_W-1:0] cnt;
	logic                        unit;
	logic [asgs_pkg::COUNT_W-1:0] pos_nx;
	logic [asgs_pkg::SLOT_W-1:0] slot;
	logic [asgs_pkg::CHAN_W-1:0] chan;

	logic                        set_ready;
	logic                        set_buf;
	logic                        st_we;
	asgs_pkg::status_t           st_new;
	logic                        pos_we;
	logic [asgs_pkg::POS_W-1:0]  pos_new;

	// Decode the group and look up its configuration
	always_comb begin
		gok     = {1'b0, group} < 5'(GC);
		gi      = group[asgs_pkg::GI_W-1:0];
		ci      = group[1:0];
		gstat   = gok ? status_q[gi] : asgs_pkg::ST_IDLE;
		raw_cnt = counts_q[ci*asgs_pkg::COUNT_W +: asgs_pkg::COUNT_W];
		if (raw_cnt == '0) begin
			cnt = asgs_pkg::COUNT_W'(1);
		end else if (raw_cnt > asgs_pkg::COUNT_W'(CPG)) begin
			cnt = asgs_pkg::COUNT_W'(CPG);
		end else begin
			cnt = raw_cnt;
		end
		unit   = (asgs_pkg::UNIT_COUNT > 1) ? umap_q[ci] : 1'b0;
		pos_nx = asgs_pkg::COUNT_W'(pos_q[gi]) + asgs_pkg::COUNT_W'(1);
		slot   = (asgs_pkg::op_t'(op) == asgs_pkg::OP_START) ? '0
			: pos_nx[asgs_pkg::SLOT_W-1:0];
		chan   = list_q[ci][slot*asgs_pkg::CHAN_W +: asgs_pkg::CHAN_W];
	end

	// Check the op, build its job and work out the state update
	always_comb begin
		job_push  = 1'b0;
		job       = '0;
		job.res.last = 1'b1;
		job.waddr = asgs_pkg::store_addr(gi, pos_q[gi]);
		job.wdata = sample[asgs_pkg::SAMPLE_W-1:0];
		job.rgroup = gi;
		job.rlast  = asgs_pkg::POS_W'(cnt - asgs_pkg::COUNT_W'(1));
		set_ready = 1'b0;
		set_buf   = 1'b0;
		st_we     = 1'b0;
		st_new    = asgs_pkg::ST_IDLE;
		pos_we    = 1'b0;
		pos_new   = '0;

		case (asgs_pkg::op_t'(op))
			asgs_pkg::OP_INIT, asgs_pkg::OP_BUF_READY, asgs_pkg::OP_START,
			asgs_pkg::OP_POLL, asgs_pkg::OP_READ: begin
				job_push = accept;
			end
			default: begin
				job_push = 1'b0;
			end
		endcase

		if (asgs_pkg::op_t'(op) == asgs_pkg::OP_INIT) begin
			if (ready_q) begin
				job.res.error  = asgs_pkg::ERR_ALREADY;
				job.res.status = gstat;
			end else begin
				job.res.ok = 1'b1;
				set_ready  = 1'b1;
			end
		end else if (!ready_q) begin
			job.res.error = asgs_pkg::ERR_UNINIT;
		end else if (!gok) begin
			job.res.error = asgs_pkg::ERR_BAD_GROUP;
		end else begin
			job.res.status = gstat;
			case (asgs_pkg::op_t'(op))
				asgs_pkg::OP_BUF_READY: begin
					job.res.ok = 1'b1;
					set_buf    = 1'b1;
				end
				asgs_pkg::OP_START: begin
					if (!buf_q[gi]) begin
						job.res.error = asgs_pkg::ERR_BUF_UNSET;
					end else if (gstat == asgs_pkg::ST_BUSY) begin
						job.res.error = asgs_pkg::ERR_BUSY;
					end else begin
						job.res.ok      = 1'b1;
						job.res.status  = asgs_pkg::ST_BUSY;
						job.res.cmd     = asgs_pkg::CMD_START;
						job.res.unit    = unit;
						job.res.channel = chan;
						st_we   = 1'b1;
						st_new  = asgs_pkg::ST_BUSY;
						pos_we  = 1'b1;
						pos_new = '0;
					end
				end
				asgs_pkg::OP_POLL: begin
					job.res.ok = 1'b1;
					if (gstat == asgs_pkg::ST_BUSY && conversion_done) begin
						job.we       = 1'b1;
						job.res.unit = unit;
						if (pos_nx < cnt) begin
							job.res.cmd     = asgs_pkg::CMD_START;
							job.res.channel = chan;
							pos_we  = 1'b1;
							pos_new = pos_nx[asgs_pkg::POS_W-1:0];
						end else begin
							job.res.cmd    = asgs_pkg::CMD_DISABLE;
							job.res.status = asgs_pkg::ST_DONE;
							st_we  = 1'b1;
							st_new = asgs_pkg::ST_DONE;
						end
					end
				end
				asgs_pkg::OP_READ: begin
					if (gstat != asgs_pkg::ST_DONE) begin
						job.res.error = asgs_pkg::ERR_NOT_DONE;
					end else begin
						job.is_read = 1'b1;
						st_we  = 1'b1;
						st_new = asgs_pkg::ST_IDLE;
					end
				end
				default: begin
					job.res.ok = 1'b0;
				end
			endcase
		end
	end

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < asgs_pkg::LIST_GROUPS; i++) begin
				list_q[i] <= '0;
			end
			counts_q <= 16'h1111;
			umap_q   <= '0;
		end else if (wr_en) begin
			if (wr_index < asgs_pkg::REG_COUNTS) begin
				list_q[wr_index[1:0]] <= wr_data;
			end else if (wr_index == asgs_pkg::REG_COUNTS) begin
				counts_q <= wr_data[asgs_pkg::COUNTS_W-1:0];
			end else if (wr_index == asgs_pkg::REG_UNIT_MAP) begin
				umap_q <= wr_data[asgs_pkg::UMAP_W-1:0];
			end
		end
	end

	// Update module and group state on each accepted op
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q <= 1'b0;
			buf_q   <= '0;
			for (int i = 0; i < GC; i++) begin
				status_q[i] <= asgs_pkg::ST_IDLE;
				pos_q[i]    <= '0;
			end
		end else if (job_push) begin
			if (set_ready) begin
				ready_q <= 1'b1;
				buf_q   <= '0;
				for (int i = 0; i < GC; i++) begin
					status_q[i] <= asgs_pkg::ST_IDLE;
					pos_q[i]    <= '0;
				end
			end
			if (set_buf) begin
				buf_q[gi] <= 1'b1;
			end
			if (st_we) begin
				status_q[gi] <= st_new;
			end
			if (pos_we) begin
				pos_q[gi] <= pos_new;
			end
		end
	end

endmodule

### src/asgs_job_q.sv
// Two-entry job queue between front and back end.
module asgs_job_q (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  asgs_pkg::job_t  push_data,
	output logic            full,
	input  logic            pop,
	output logic            valid,
	output asgs_pkg::job_t  head
);

	asgs_pkg::job_t entry_q [2];
	logic           wp_q;
	logic           rp_q;
	logic [1:0]     cnt_q;

	assign full  = cnt_q == 2'd2;
	assign valid = cnt_q != 2'd0;
	assign head  = entry_q[rp_q];

	// Store pushed jobs
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wp_q] <= push_data;
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

### src/asgs_back.sv
// Back end: sample store, result streaming and the output queue.
module asgs_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                job_valid,
	input  asgs_pkg::job_t      job,
	output logic                job_pop,
	input  logic                pop,
	output logic                empty,
	output asgs_pkg::result_t   head
);

	asgs_pkg::bk_state_t          state_q, state_d;
	logic [asgs_pkg::GI_W-1:0]    rgrp_q, rgrp_d;
	logic [asgs_pkg::POS_W-1:0]   rlast_q, rlast_d;
	logic [asgs_pkg::POS_W-1:0]   idx_q, idx_d;
	logic                         rd_valid_s1;
	logic                         rd_last_s1;
	logic                         issue;
	logic                         issue_last;

	logic                         ram_we;
	logic [asgs_pkg::ADDR_W-1:0]  ram_raddr;
	logic [asgs_pkg::SAMPLE_W-1:0] ram_rdata;

	asgs_pkg::result_t            oq_q [asgs_pkg::OQ_DEPTH];
	logic [asgs_pkg::OQ_PTR_W-1:0] oq_wp_q;
	logic [asgs_pkg::OQ_PTR_W-1:0] oq_rp_q;
	logic [asgs_pkg::OQ_CNT_W-1:0] oq_cnt_q;
	logic                         oq_push;
	logic                         oq_pop;
	asgs_pkg::result_t            oq_data;
	logic                         room;

	asgs_ram #(
		.WIDTH(asgs_pkg::SAMPLE_W),
		.DEPTH(asgs_pkg::STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(job.waddr),
		.wdata(job.wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign empty  = oq_cnt_q == '0;
	assign oq_pop = pop && !empty;
	assign head   = oq_q[oq_rp_q];

	// Room for one more read counting the sample already in flight
	assign room = ({1'b0, oq_cnt_q} + (asgs_pkg::OQ_CNT_W + 1)'(rd_valid_s1))
		< (asgs_pkg::OQ_CNT_W + 1)'(asgs_pkg::OQ_DEPTH);

	// Sequence jobs: single results pass through, reads stream the store
	always_comb begin
		state_d    = state_q;
		rgrp_d     = rgrp_q;
		rlast_d    = rlast_q;
		idx_d      = idx_q;
		job_pop    = 1'b0;
		ram_we     = 1'b0;
		ram_raddr  = asgs_pkg::store_addr(rgrp_q, idx_q);
		issue      = 1'b0;
		issue_last = idx_q == rlast_q;
		oq_push    = 1'b0;
		oq_data    = '0;

		if (rd_valid_s1) begin
			oq_push       = 1'b1;
			oq_data.ok    = 1'b1;
			oq_data.value = ram_rdata;
			oq_data.last  = rd_last_s1;
		end

		case (state_q)
			asgs_pkg::BK_IDLE: begin
				if (job_valid) begin
					if (job.is_read) begin
						job_pop = 1'b1;
						rgrp_d  = job.rgroup;
						rlast_d = job.rlast;
						idx_d   = '0;
						state_d = asgs_pkg::BK_READ;
					end else if (!rd_valid_s1
							&& oq_cnt_q < asgs_pkg::OQ_CNT_W'(asgs_pkg::OQ_DEPTH)) begin
						job_pop = 1'b1;
						oq_push = 1'b1;
						oq_data = job.res;
						ram_we  = job.we;
					end
				end
			end
			asgs_pkg::BK_READ: begin
				if (room) begin
					issue = 1'b1;
					if (issue_last) begin
						state_d = asgs_pkg::BK_IDLE;
					end else begin
						idx_d = idx_q + asgs_pkg::POS_W'(1);
					end
				end
			end
			default: begin
				state_d = asgs_pkg::BK_IDLE;
			end
		endcase
	end

	// Hold sequencer state and the read pipeline stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= asgs_pkg::BK_IDLE;
			rd_valid_s1 <= 1'b0;
		end else begin
			state_q     <= state_d;
			rd_valid_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		rgrp_q     <= rgrp_d;
		rlast_q    <= rlast_d;
		idx_q      <= idx_d;
		rd_last_s1 <= issue_last;
	end

	// Output queue storage
	always_ff @(posedge clk) begin
		if (oq_push) begin
			oq_q[oq_wp_q] <= oq_data;
		end
	end

	// Output queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wp_q  <= '0;
			oq_rp_q  <= '0;
			oq_cnt_q <= '0;
		end else begin
			if (oq_push) begin
				oq_wp_q <= oq_wp_q + asgs_pkg::OQ_PTR_W'(1);
			end
			if (oq_pop) begin
				oq_rp_q <= oq_rp_q + asgs_pkg::OQ_PTR_W'(1);
			end
			oq_cnt_q <= oq_cnt_q + asgs_pkg::OQ_CNT_W'(oq_push)
				- asgs_pkg::OQ_CNT_W'(oq_pop);
		end
	end

endmodule

### src/adc_group_scan_sequencer_unit.sv
// Top level of the ADC group scan sequencer.
// Per-group ADC scan sequencer with queue-style ports on both sides. The front end
// checks each op in the cycle it is pushed, updates group state and hands a job
// to a two-entry job queue; ops 5 to 7 are taken and dropped. The back end turns
// each job into results in a four-entry output queue: a control op yields its one
// result, passed through the job queue and then the output queue, and a read
// streams one stored sample per cycle while the output queue has room, behind the
// registered store read. Room in the output queue, and so pop, paces the
// streaming; full rises once both job queue entries are taken, which happens
// when jobs wait behind a read or behind a full output queue while pop is held off.
// The sample store has no reset; read only samples a poll has written.
module adc_group_scan_sequencer_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [asgs_pkg::REG_IDX_W-1:0]    wr_index,
	input  logic [asgs_pkg::LIST_W-1:0]       wr_data,
	input  logic                              push,
	output logic                              full,
	input  logic [2:0]                        op,
	input  logic [3:0]                        group,
	input  logic                              conversion_done,
	input  logic [15:0]                       sample,
	output logic                              empty,
	input  logic                              pop,
	output logic                              ok,
	output logic [2:0]                        error,
	output logic [1:0]                        status,
	output logic [1:0]                        convert_cmd,
	output logic                              convert_unit,
	output logic [4:0]                        convert_channel,
	output logic [11:0]                       value,
	output logic                              last
);

	logic               accept;
	logic               job_push;
	asgs_pkg::job_t     job_in;
	logic               job_valid;
	logic               job_pop;
	asgs_pkg::job_t     job_head;
	asgs_pkg::result_t  res;

	assign accept = push && !full;

	asgs_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.wr_en          (wr_en),
		.wr_index       (wr_index),
		.wr_data        (wr_data),
		.accept         (accept),
		.op             (op),
		.group          (group),
		.conversion_done(conversion_done),
		.sample         (sample),
		.job_push       (job_push),
		.job            (job_in)
	);

	asgs_job_q u_job_q (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (job_push),
		.push_data(job_in),
		.full     (full),
		.pop      (job_pop),
		.valid    (job_valid),
		.head     (job_head)
	);

	asgs_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_valid(job_valid),
		.job      (job_head),
		.job_pop  (job_pop),
		.pop      (pop),
		.empty    (empty),
		.head     (res)
	);

	// Drive result ports from the oldest queued beat
	assign ok              = res.ok;
	assign error           = res.error;
	assign status          = res.status;
	assign convert_cmd     = res.cmd;
	assign convert_unit    = res.unit;
	assign convert_channel = res.channel;
	assign value           = res.value;
	assign last            = res.last;

endmodule

### dv/tb_adc_group_scan_sequencer_unit.sv
// Self-checking testbench of the ADC group scan sequencer unit.
module tb_adc_group_scan_sequencer_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import asgs_pkg::*;

	// Op codes outside the defined set, taken and dropped by the block
	localparam logic [2:0] OP_SPARE_LO = 3'd5;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;
	localparam int SLOTS       = CHANNELS_PER_GROUP;
	localparam int TAIL_CYCLES = 24;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		logic [2:0]  op;
		logic [3:0]  grp;
		logic        done;
		logic [15:0] smp;
	} scan_req_t;

	// Group state mirror plus the queue of results still owed by the block
	class scan_scoreboard;
		logic [LIST_W-1:0]   chan_list [LIST_GROUPS];
		logic [COUNTS_W-1:0] chan_counts;
		logic [UMAP_W-1:0]   unit_map;
		bit                  ready;
		bit                  buf_set [GROUP_COUNT];
		status_t             grp_st [GROUP_COUNT];
		logic [3:0]          scan_pos [GROUP_COUNT];
		logic [SAMPLE_W-1:0] samples [GROUP_COUNT*SLOTS];
		bit                  written [GROUP_COUNT*SLOTS];
		result_t             due_results [$];
		int                  mismatches;

		function new();
			chan_counts = 16'h1111;
			unit_map    = '0;
			ready       = 0;
			mismatches  = 0;
			foreach (chan_list[i]) chan_list[i] = '0;
			foreach (buf_set[i]) begin
				buf_set[i]  = 0;
				grp_st[i]   = ST_IDLE;
				scan_pos[i] = '0;
			end
			foreach (written[i]) begin
				written[i] = 0;
				samples[i] = '0;
			end
		endfunction

		function void set_reg(logic [REG_IDX_W-1:0] idx, logic [LIST_W-1:0] data);
			if (idx < REG_COUNTS) chan_list[idx] = data;
			else if (idx == REG_COUNTS) chan_counts = data[COUNTS_W-1:0];
			else if (idx == REG_UNIT_MAP) unit_map = data[UMAP_W-1:0];
		endfunction

		// Zero counts mean one channel, counts above the slot count saturate
		function int scan_len(int g);
			int c;
			c = chan_counts[COUNT_W*(g % LIST_GROUPS) +: COUNT_W];
			if (c == 0) c = 1;
			if (c > SLOTS) c = SLOTS;
			return c;
		endfunction

		function logic unit_of(int g);
			logic u;
			u = unit_map[g % LIST_GROUPS];
			return (int'(u) < UNIT_COUNT) ? u : 1'b0;
		endfunction

		function logic [CHAN_W-1:0] chan_of(int g, int slot);
			return chan_list[g % LIST_GROUPS][CHAN_W*(slot % SLOTS) +: CHAN_W];
		endfunction

		function void add(bit okv, error_t err, status_t st, cmd_t cmd, logic u,
				logic [CHAN_W-1:0] ch, logic [SAMPLE_W-1:0] val, bit lst);
			result_t r;
			r.ok      = okv;
			r.error   = err;
			r.status  = st;
			r.cmd     = cmd;
			r.unit    = u;
			r.channel = ch;
			r.value   = val;
			r.last    = lst;
			due_results.push_back(r);
		endfunction

		// False only when a read would stream a slot that no poll has filled
		function bit read_in_contract(logic [3:0] grp);
			if (!ready || grp >= GROUP_COUNT || grp_st[grp] != ST_DONE) return 1;
			for (int i = 0; i < scan_len(grp); i++)
				if (!written[grp*SLOTS + i]) return 0;
			return 1;
		endfunction

		// Advance group state by one accepted op and queue the results it owes
		function void apply_op(scan_req_t it);
			int g;
			int p;
			int n;
			bit gok;
			g   = it.grp;
			gok = g < GROUP_COUNT;
			if (it.op > OP_READ) return;
			if (it.op == OP_INIT) begin
				if (ready) begin
					add(0, ERR_ALREADY, gok ? grp_st[g] : ST_IDLE, CMD_NONE, 0, 0, 0, 1);
				end else begin
					foreach (buf_set[i]) begin
						buf_set[i]  = 0;
						grp_st[i]   = ST_IDLE;
						scan_pos[i] = '0;
					end
					ready = 1;
					add(1, ERR_NONE, ST_IDLE, CMD_NONE, 0, 0, 0, 1);
				end
				return;
			end
			if (!ready) begin
				add(0, ERR_UNINIT, ST_IDLE, CMD_NONE, 0, 0, 0, 1);
				return;
			end
			if (!gok) begin
				add(0, ERR_BAD_GROUP, ST_IDLE, CMD_NONE, 0, 0, 0, 1);
				return;
			end
			case (it.op)
				OP_BUF_READY: begin
					buf_set[g] = 1;
					add(1, ERR_NONE, grp_st[g], CMD_NONE, 0, 0, 0, 1);
				end
				OP_START: begin
					if (!buf_set[g]) begin
						add(0, ERR_BUF_UNSET, grp_st[g], CMD_NONE, 0, 0, 0, 1);
					end else if (grp_st[g] == ST_BUSY) begin
						add(0, ERR_BUSY, ST_BUSY, CMD_NONE, 0, 0, 0, 1);
					end else begin
						scan_pos[g] = '0;
						grp_st[g]   = ST_BUSY;
						add(1, ERR_NONE, ST_BUSY, CMD_START, unit_of(g), chan_of(g, 0), 0, 1);
					end
				end
				OP_POLL: begin
					if (grp_st[g] == ST_BUSY && it.done) begin
						// store the sample, then issue the next channel or disable
						p = scan_pos[g] % SLOTS;
						samples[g*SLOTS + p] = it.smp[SAMPLE_W-1:0];
						written[g*SLOTS + p] = 1;
						p++;
						scan_pos[g] = 4'(p);
						if (p < scan_len(g)) begin
							add(1, ERR_NONE, ST_BUSY, CMD_START, unit_of(g), chan_of(g, p), 0, 1);
						end else begin
							grp_st[g] = ST_DONE;
							add(1, ERR_NONE, ST_DONE, CMD_DISABLE, unit_of(g), 0, 0, 1);
						end
					end else begin
						add(1, ERR_NONE, grp_st[g], CMD_NONE, 0, 0, 0, 1);
					end
				end
				default: begin
					if (grp_st[g] != ST_DONE) begin
						add(0, ERR_NOT_DONE, grp_st[g], CMD_NONE, 0, 0, 0, 1);
					end else begin
						grp_st[g] = ST_IDLE;
						n = scan_len(g);
						for (int i = 0; i < n; i++)
							add(1, ERR_NONE, ST_IDLE, CMD_NONE, 0, 0, samples[g*SLOTS + i],
								i == n - 1);
					end
				end
			endcase
		endfunction

		task report_mismatch(string msg);
			$display("[%0t] MISMATCH %s", $time, msg);
			mismatches++;
		endtask

		task cmp(string name, logic [15:0] got_v, logic [15:0] want_v);
			if (got_v !== want_v)
				report_mismatch($sformatf("%s: got %0h, want %0h", name, got_v, want_v));
		endtask

		task check_result(result_t got);
			result_t want;
			if (due_results.size() == 0) begin
				report_mismatch($sformatf("result beat with nothing due: %h", got));
				return;
			end
			want = due_results.pop_front();
			cmp("ok", got.ok, want.ok);
			cmp("error", got.error, want.error);
			cmp("status", got.status, want.status);
			cmp("convert_cmd", got.cmd, want.cmd);
			cmp("convert_unit", got.unit, want.unit);
			cmp("convert_channel", got.channel, want.channel);
			cmp("value", got.value, want.value);
			cmp("last", got.last, want.last);
		endtask
	endclass

	logic                 clk             = 1'b0;
	logic                 arst_n          = 1'b0;
	logic                 wr_en           = 1'b0;
	logic [REG_IDX_W-1:0] wr_index        = '0;
	logic [LIST_W-1:0]    wr_data         = '0;
	logic                 push            = 1'b0;
	logic                 full;
	logic [2:0]           op              = '0;
	logic [3:0]           group           = '0;
	logic                 conversion_done = 1'b0;
	logic [15:0]          sample          = '0;
	logic                 empty;
	logic                 pop             = 1'b0;
	logic                 ok;
	logic [2:0]           error;
	logic [1:0]           status;
	logic [1:0]           convert_cmd;
	logic                 convert_unit;
	logic [4:0]           convert_channel;
	logic [11:0]          value;
	logic                 last;

	int             send_idle = 0;
	int             recv_idle = 0;
	bit             hold_req  = 0;
	scan_scoreboard sb;

	adc_group_scan_sequencer_unit i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.wr_en           (wr_en),
		.wr_index        (wr_index),
		.wr_data         (wr_data),
		.push            (push),
		.full            (full),
		.op              (op),
		.group           (group),
		.conversion_done (conversion_done),
		.sample          (sample),
		.empty           (empty),
		.pop             (pop),
		.ok              (ok),
		.error           (error),
		.status          (status),
		.convert_cmd     (convert_cmd),
		.convert_unit    (convert_unit),
		.convert_channel (convert_channel),
		.value           (value),
		.last            (last)
	);

	always #4 clk = ~clk;

	function automatic logic [LIST_W-1:0] rand_list();
		return LIST_W'({$urandom, $urandom});
	endfunction

	// Mostly well-formed scan traffic per group, with some raw noise mixed in
	function automatic scan_req_t make_item();
		scan_req_t it;
		int g;
		it.smp  = 16'($urandom);
		it.done = 1'($urandom_range(1));
		if ($urandom_range(99) < 12) begin
			it.op  = 3'($urandom_range(7));
			it.grp = 4'($urandom_range(15));
		end else begin
			g = $urandom_range(GROUP_COUNT - 1);
			it.grp = 4'(g);
			if (!sb.ready) begin
				it.op = OP_INIT;
			end else if (!sb.buf_set[g] || $urandom_range(99) < 4) begin
				it.op = OP_BUF_READY;
			end else begin
				case (sb.grp_st[g])
					ST_BUSY: begin
						it.op   = OP_POLL;
						it.done = $urandom_range(99) < 85;
					end
					ST_DONE: it.op = ($urandom_range(99) < 85) ? OP_READ : OP_START;
					default: it.op = ($urandom_range(99) < 90) ? OP_START : OP_POLL;
				endcase
			end
		end
		// keep reads away from slots that were never filled
		if (it.op == OP_READ && !sb.read_in_contract(it.grp)) it.op = OP_POLL;
		return it;
	endfunction

	// Offer one beat, hold it until taken, then mirror it; returns on a falling edge
	task automatic send_item(scan_req_t it);
		while ($urandom_range(99) < send_idle) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push            <= 1'b1;
		op              <= it.op;
		group           <= it.grp;
		conversion_done <= it.done;
		sample          <= it.smp;
		do @(posedge clk); while (full);
		sb.apply_op(it);
		@(negedge clk);
	endtask

	task automatic send(logic [2:0] o, logic [3:0] g, logic d, logic [15:0] s);
		scan_req_t it;
		it.op   = o;
		it.grp  = g;
		it.done = d;
		it.smp  = s;
		send_item(it);
	endtask

	// Drop push and wait until every due result has been popped, plus a tail
	task automatic settle();
		push <= 1'b0;
		while (sb.due_results.size() != 0) @(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [LIST_W-1:0] data);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		sb.set_reg(idx, data);
		@(negedge clk);
	endtask

	task automatic load_config(logic [LIST_W-1:0] l0, logic [LIST_W-1:0] l1,
			logic [LIST_W-1:0] l2, logic [LIST_W-1:0] l3,
			logic [COUNTS_W-1:0] cnt, logic [UMAP_W-1:0] um);
		write_reg(REG_LIST_G0, l0);
		write_reg(REG_LIST_G0 + 3'd1, l1);
		write_reg(REG_LIST_G0 + 3'd2, l2);
		write_reg(REG_LIST_G0 + 3'd3, l3);
		write_reg(REG_COUNTS, LIST_W'(cnt));
		write_reg(REG_UNIT_MAP, LIST_W'(um));
		wr_en <= 1'b0;
	endtask

	task automatic run_phase(int n, int s_idle, int r_idle, bit long_hold, int pause_at);
		send_idle = s_idle;
		recv_idle = r_idle;
		if (long_hold) hold_req = 1;
		for (int i = 0; i < n; i++) begin
			if (i == pause_at) settle();
			send_item(make_item());
		end
		settle();
	endtask

	// Result side: pop at random, or hold off for a long stretch on request
	initial begin
		result_t got;
		int hold_left;
		hold_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req  = 0;
			end
			if (hold_left > 0) begin
				pop <= 1'b0;
				hold_left--;
			end else begin
				pop <= ($urandom_range(99) >= recv_idle);
			end
			@(posedge clk);
			if (pop && !empty) begin
				got.ok      = ok;
				got.error   = error_t'(error);
				got.status  = status_t'(status);
				got.cmd     = cmd_t'(convert_cmd);
				got.unit    = convert_unit;
				got.channel = convert_channel;
				got.value   = value;
				got.last    = last;
				sb.check_result(got);
			end
		end
	end

	initial begin
		sb = new();
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		// g0 scans two channels, g1 a zero count, g2 eight, g3 a saturated count
		load_config(rand_list(), rand_list(), rand_list(), rand_list(), 16'hF802, 4'b0101);

		// uninitialized ops, spare op codes, init twice, then error order per group
		send(OP_POLL, 4'd0, 1'b1, 16'h0123);
		send(OP_SPARE_LO, 4'd0, 1'b0, 16'h0000);
		send(OP_SPARE_HI, 4'd15, 1'b1, 16'hFFFF);
		send(OP_READ, 4'd9, 1'b0, 16'h0000);
		send(OP_INIT, 4'd3, 1'b0, 16'h0000);
		send(OP_INIT, 4'd0, 1'b1, 16'hFFFF);
		send(OP_POLL, 4'd15, 1'b1, 16'hFFFF);
		send(OP_START, 4'd4, 1'b0, 16'h0000);
		send(OP_START, 4'd1, 1'b0, 16'h0000);
		send(OP_READ, 4'd1, 1'b0, 16'h0000);
		send(OP_BUF_READY, 4'd1, 1'b0, 16'h0000);
		send(OP_POLL, 4'd1, 1'b1, 16'h5A5A);
		send(OP_START, 4'd1, 1'b0, 16'h0000);
		send(OP_START, 4'd1, 1'b0, 16'h0000);
		send(OP_POLL, 4'd1, 1'b0, 16'h1234);
		send(OP_POLL, 4'd1, 1'b1, 16'hFFFF);
		send(OP_READ, 4'd1, 1'b0, 16'h0000);
		send(OP_BUF_READY, 4'd0, 1'b1, 16'h0000);
		send(OP_START, 4'd0, 1'b0, 16'h0000);
		send(OP_POLL, 4'd0, 1'b1, 16'h0000);
		send(OP_POLL, 4'd0, 1'b1, 16'hFABC);
		send(OP_READ, 4'd0, 1'b0, 16'h0000);
		send(OP_INIT, 4'd7, 1'b0, 16'h0000);
		settle();

		// full-length scans on unit 1, slow receiver
		load_config(rand_list(), rand_list(), rand_list(), rand_list(), 16'h8888, 4'hF);
		run_phase(70, 32, 80, 0, -1);

		// single-channel scans on unit 0, slow sender; cuts short any scan in flight
		load_config({LIST_W{1'b1}}, '0, rand_list(), rand_list(), 16'h0000, 4'h0);
		run_phase(70, 80, 32, 0, -1);

		// random counts, no idling, full drain partway through
		load_config(rand_list(), rand_list(), rand_list(), rand_list(),
			16'($urandom), 4'($urandom));
		run_phase(70, 0, 0, 0, 35);

		// saturated counts with a long receiver hold so the input backs up
		load_config(rand_list(), rand_list(), rand_list(), rand_list(), 16'hFFFF,
			4'($urandom));
		run_phase(75, 0, 0, 1, -1);

		if (sb.mismatches == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// Watchdog far beyond the slowest legal run
	initial begin
		#4_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

### files.f
src/asgs_pkg.sv
src/asgs_ram.sv
src/asgs_front.sv
src/asgs_job_q.sv
src/asgs_back.sv
src/adc_group_scan_sequencer_unit.sv
dv/tb_adc_group_scan_sequencer_unit.sv
